>>> hdl/dod_pkg.sv
// ----------------------------------------------------------------------------
// Duplicate offset detector package
// Shared widths, status codes and the result record passed from the sequencer
// to the output stage.
// ----------------------------------------------------------------------------
package dod_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_W  = OFFSET_W + TAG_W;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VALID     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    earlier_tag;
    logic [TAG_W-1:0]    current_tag;
    logic [OFFSET_W-1:0] clash_offset;
  } res_t;

endpackage

>>> hdl/dod_ram.sv
// ----------------------------------------------------------------------------
// Duplicate offset detector RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dod_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/dod_scan.sv
// ----------------------------------------------------------------------------
// Duplicate offset detector scan sequencer
// Walks the stored offsets one per cycle through the shared comparator,
// appends misses to the table and tracks the per-directory fail flag.
// ----------------------------------------------------------------------------
module dod_scan #(
  parameter int unsigned MAX_ENTRIES = dod_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         holds_offset_i,
  input  logic [dod_pkg::OFFSET_W-1:0] entry_offset_i,
  input  logic [dod_pkg::TAG_W-1:0]    entry_tag_i,
  input  logic                         last_entry_i,
  output logic                         res_valid_o,
  output dod_pkg::res_t                res_o,
  input  logic                         res_take_i,
  output logic                         ram_rd_en_o,
  output logic [AW-1:0]                ram_rd_addr_o,
  input  logic [dod_pkg::ENTRY_W-1:0]  ram_rd_data_i,
  output logic                         ram_wr_en_o,
  output logic [AW-1:0]                ram_wr_addr_o,
  output logic [dod_pkg::ENTRY_W-1:0]  ram_wr_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic                         failed_q, failed_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [dod_pkg::OFFSET_W-1:0] off_q, off_d;
  logic [dod_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic                         last_q, last_d;
  dod_pkg::res_t                res_q, res_d;

  logic                         fin;
  logic [dod_pkg::STATUS_W-1:0] fin_status;
  logic [dod_pkg::TAG_W-1:0]    fin_prev;
  logic [dod_pkg::OFFSET_W-1:0] fin_clash;
  logic                         cur_last;
  logic [dod_pkg::TAG_W-1:0]    cur_tag;
  logic                         hit;
  logic                         rd_en;

  assign cur_last = (state_q == S_IDLE) ? last_entry_i : last_q;
  assign cur_tag  = (state_q == S_IDLE) ? entry_tag_i  : tag_q;
  assign hit      = rd_vld_q && (ram_rd_data_i[dod_pkg::OFFSET_W-1:0] == off_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    failed_d    = failed_q;
    rd_vld_d    = 1'b0;
    off_d       = off_q;
    tag_d       = tag_q;
    last_d      = last_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    ram_wr_en_o = 1'b0;
    fin         = 1'b0;
    fin_status  = dod_pkg::ST_ACCEPTED;
    fin_prev    = '0;
    fin_clash   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          off_d  = entry_offset_i;
          tag_d  = entry_tag_i;
          last_d = last_entry_i;
          priority if (failed_q) begin
            fin        = 1'b1;
            fin_status = dod_pkg::ST_IGNORED;
          end else if (!holds_offset_i) begin
            fin = 1'b1;
          end else begin
            ptr_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = (ptr_q != cnt_q) && !hit;
        priority if (hit) begin
          fin        = 1'b1;
          fin_status = dod_pkg::ST_DUPLICATE;
          fin_prev   = ram_rd_data_i[dod_pkg::ENTRY_W-1:dod_pkg::OFFSET_W];
          fin_clash  = off_q;
          failed_d   = 1'b1;
        end else if (rd_en) begin
          ptr_d    = ptr_q + CW'(1);
          rd_vld_d = 1'b1;
        end else begin
          fin = 1'b1;
          if (cnt_q == CW'(MAX_ENTRIES)) begin
            fin_status = dod_pkg::ST_OVERFLOW;
            failed_d   = 1'b1;
          end else begin
            ram_wr_en_o = 1'b1;
            cnt_d       = cnt_q + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (cur_last) begin
        if (fin_status == dod_pkg::ST_ACCEPTED) begin
          fin_status = dod_pkg::ST_VALID;
        end
        cnt_d    = '0;
        failed_d = 1'b0;
      end
      res_d.status       = fin_status;
      res_d.earlier_tag  = fin_prev;
      res_d.current_tag  = cur_tag;
      res_d.clash_offset = fin_clash;
      state_d            = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      failed_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    off_q  <= off_d;
    tag_q  <= tag_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign res_o         = res_q;
  assign ram_rd_en_o   = rd_en;
  assign ram_rd_addr_o = ptr_q[AW-1:0];
  assign ram_wr_addr_o = cnt_q[AW-1:0];
  assign ram_wr_data_o = {tag_q, off_q};

endmodule

>>> hdl/duplicate_offset_detector_top.sv
// Throughput: one entry at a time; the scan reads one stored offset per cycle
//   through a single comparator, and the input is held until the result is
//   taken by the output stage; inline and ignored entries skip the scan.
// Reset: asynchronous, active low; clears the count and fail flag, table
//   contents stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
// Duplicate offset detector top level
// Flags offsets used twice within one directory and table overflow.
// ----------------------------------------------------------------------------
module duplicate_offset_detector_top #(
  parameter int unsigned MAX_ENTRIES = dod_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         holds_offset_i,
  input  logic [dod_pkg::OFFSET_W-1:0] entry_offset_i,
  input  logic [dod_pkg::TAG_W-1:0]    entry_tag_i,
  input  logic                         last_entry_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dod_pkg::STATUS_W-1:0] status_o,
  output logic [dod_pkg::TAG_W-1:0]    earlier_tag_o,
  output logic [dod_pkg::TAG_W-1:0]    current_tag_o,
  output logic [dod_pkg::OFFSET_W-1:0] clash_offset_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic                        res_valid;
  dod_pkg::res_t               res;
  logic                        res_take;
  logic                        ram_rd_en;
  logic [AW-1:0]               ram_rd_addr;
  logic [dod_pkg::ENTRY_W-1:0] ram_rd_data;
  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [dod_pkg::ENTRY_W-1:0] ram_wr_data;

  logic                        out_valid_q;
  dod_pkg::res_t               out_q;

  dod_scan #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .holds_offset_i(holds_offset_i),
    .entry_offset_i(entry_offset_i),
    .entry_tag_i   (entry_tag_i),
    .last_entry_i  (last_entry_i),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_take_i    (res_take),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  dod_ram #(
    .WIDTH(dod_pkg::ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign earlier_tag_o  = out_q.earlier_tag;
  assign current_tag_o  = out_q.current_tag;
  assign clash_offset_o = out_q.clash_offset;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not held off after transaction");

  a_clean_non_dup: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != dod_pkg::ST_DUPLICATE))
      |-> (earlier_tag_o == '0) && (clash_offset_o == '0)
  ) else $error("clash fields set without duplicate");

  a_result_from_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared with no entry in progress");

endmodule
